/* rtl/glsa_pkg.sv */
// Shared types, constants and the arctangent table for the gimbal linkage servo angle core.
`default_nettype none

package glsa_pkg;

  localparam int unsigned CORDIC_STAGES_DEF = 16;
  localparam int unsigned ATAN_ENTRIES      = 32;

  // Datapath widths.
  localparam int unsigned ANG_W  = 26;  // Q16 degrees accumulator
  localparam int unsigned ROT_W  = 34;  // Q28 lengths in the rotation unit
  localparam int unsigned PT_W   = 18;  // Q12 hole coordinates
  localparam int unsigned OFS_W  = 19;  // Q12 offsets from the servo pivot
  localparam int unsigned NUM_W  = 56;  // numerator and denominator
  localparam int unsigned AT_W   = 58;  // vectoring unit lengths

  localparam logic [29:0] GAIN_Q30 = 30'd652032875;
  localparam logic signed [ANG_W-1:0] DEG90_Q16  = 26'sd5898240;
  localparam logic signed [ANG_W-1:0] DEG180_Q16 = 26'sd11796480;
  localparam logic signed [15:0] OUT_LIMIT = 16'sd23040;

  localparam logic [14:0]        PIVOT_DISTANCE_RST = 15'd17203;
  localparam logic signed [15:0] YAW_SERVO_X_RST    = -16'sd11469;
  localparam logic signed [15:0] PITCH_SERVO_X_RST  = -16'sd10445;
  localparam logic signed [15:0] SERVO_Y_RST        = 16'sd11878;
  localparam logic [14:0]        HORN_RADIUS_RST    = 15'd4506;
  localparam logic [14:0]        ROD_LENGTH_RST     = 15'd11469;

  typedef enum logic [2:0] {
    REG_PIVOT_DISTANCE = 3'd0,
    REG_YAW_SERVO_X    = 3'd1,
    REG_PITCH_SERVO_X  = 3'd2,
    REG_SERVO_Y        = 3'd3,
    REG_HORN_RADIUS    = 3'd4,
    REG_ROD_LENGTH     = 3'd5
  } reg_index_t;

  typedef struct packed {
    logic [14:0]        pivot_distance;
    logic signed [15:0] yaw_servo_x;
    logic signed [15:0] pitch_servo_x;
    logic signed [15:0] servo_y;
    logic [14:0]        horn_radius;
    logic [14:0]        rod_length;
  } cfg_t;

  // atan(2^-i) in degrees, Q16.
  function automatic logic signed [ANG_W-1:0] atan_q16(input int unsigned idx);
    logic signed [ANG_W-1:0] v;
    case (idx)
      0:  v = 26'sd2949120;
      1:  v = 26'sd1740967;
      2:  v = 26'sd919879;
      3:  v = 26'sd466945;
      4:  v = 26'sd234379;
      5:  v = 26'sd117304;
      6:  v = 26'sd58666;
      7:  v = 26'sd29335;
      8:  v = 26'sd14668;
      9:  v = 26'sd7334;
      10: v = 26'sd3667;
      11: v = 26'sd1833;
      12: v = 26'sd917;
      13: v = 26'sd458;
      14: v = 26'sd229;
      15: v = 26'sd115;
      16: v = 26'sd57;
      17: v = 26'sd29;
      18: v = 26'sd14;
      19: v = 26'sd7;
      20: v = 26'sd4;
      21: v = 26'sd2;
      22: v = 26'sd1;
      default: v = 26'sd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

/* rtl/gimbal_linkage_servo_angle_core.sv */
// Top level of the gimbal linkage servo angle core: registers, pipeline and handshakes.
`default_nettype none

// The core turns a gimbal angle request for the yaw or pitch axis into the servo horn
// angle in Q8 degrees, with reachable low (and angle zero) when the linkage cannot close.
// It is a fully pipelined datapath: one request is taken every cycle while the output
// is not held, and each result passes through the rotation CORDIC, the 32-step square
// root and the vectoring CORDIC. The whole pipeline holds while a finished result waits
// on the output. Write registers only while no request is in flight.

module gimbal_linkage_servo_angle_core #(
  parameter int unsigned CORDIC_STAGES = glsa_pkg::CORDIC_STAGES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [15:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               action,
  input  wire logic signed [15:0] gimbal_angle,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      servo_angle,
  output logic                    reachable
);
  import glsa_pkg::*;

  cfg_t cfg;
  logic en;

  assign en        = !out_valid || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pivot_distance <= PIVOT_DISTANCE_RST;
      cfg.yaw_servo_x    <= YAW_SERVO_X_RST;
      cfg.pitch_servo_x  <= PITCH_SERVO_X_RST;
      cfg.servo_y        <= SERVO_Y_RST;
      cfg.horn_radius    <= HORN_RADIUS_RST;
      cfg.rod_length     <= ROD_LENGTH_RST;
    end else if (cfg_valid) begin
      case (reg_index_t'(cfg_index))
        REG_PIVOT_DISTANCE: cfg.pivot_distance <= cfg_data[14:0];
        REG_YAW_SERVO_X:    cfg.yaw_servo_x    <= $signed(cfg_data);
        REG_PITCH_SERVO_X:  cfg.pitch_servo_x  <= $signed(cfg_data);
        REG_SERVO_Y:        cfg.servo_y        <= $signed(cfg_data);
        REG_HORN_RADIUS:    cfg.horn_radius    <= cfg_data[14:0];
        REG_ROD_LENGTH:     cfg.rod_length     <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  logic                   rot_valid, rot_action;
  logic signed [PT_W-1:0] rot_px, rot_py;

  glsa_rot #(.STAGES(CORDIC_STAGES)) u_rot (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (in_valid),
    .in_action  (action),
    .in_angle   (gimbal_angle),
    .pivot_dist (cfg.pivot_distance),
    .out_valid  (rot_valid),
    .out_action (rot_action),
    .out_px     (rot_px),
    .out_py     (rot_py)
  );

  logic                    geo_valid, geo_bad, geo_den_zero;
  logic signed [NUM_W-1:0] geo_num, geo_den;

  glsa_geo u_geo (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .cfg          (cfg),
    .in_valid     (rot_valid),
    .in_action    (rot_action),
    .in_px        (rot_px),
    .in_py        (rot_py),
    .out_valid    (geo_valid),
    .out_bad      (geo_bad),
    .out_den_zero (geo_den_zero),
    .out_num      (geo_num),
    .out_den      (geo_den)
  );

  glsa_atan #(.STAGES(CORDIC_STAGES)) u_atan (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .in_valid    (geo_valid),
    .in_bad      (geo_bad),
    .in_den_zero (geo_den_zero),
    .in_num      (geo_num),
    .in_den      (geo_den),
    .out_valid   (out_valid),
    .servo_angle (servo_angle),
    .reachable   (reachable)
  );

endmodule

`default_nettype wire

/* rtl/glsa_rot.sv */
// Pipelined rotation CORDIC that places the gimbal linkage hole.
`default_nettype none

module glsa_rot #(
  parameter int unsigned STAGES = glsa_pkg::CORDIC_STAGES_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              en,
  input  wire logic                              in_valid,
  input  wire logic                              in_action,
  input  wire logic signed [15:0]                in_angle,
  input  wire logic [14:0]                       pivot_dist,
  output logic                                   out_valid,
  output logic                                   out_action,
  output logic signed [glsa_pkg::PT_W-1:0]       out_px,
  output logic signed [glsa_pkg::PT_W-1:0]       out_py
);
  import glsa_pkg::*;

  localparam logic signed [ROT_W-1:0] RND16 = 34'sd32768;

  logic signed [ROT_W-1:0] xs  [STAGES+1];
  logic signed [ROT_W-1:0] ys  [STAGES+1];
  logic signed [ANG_W-1:0] zs  [STAGES+1];
  logic                    ngs [STAGES+1];
  logic                    act [STAGES+1];
  logic                    vld [STAGES+1];

  logic signed [ANG_W-1:0] z_in;
  logic signed [ANG_W-1:0] z_fold;
  logic                    neg_in;
  logic [44:0]             gain_prod;

  always_comb begin
    z_in = $signed({{(ANG_W-24){in_angle[15]}}, in_angle, 8'b0});
    z_fold = z_in;
    neg_in = 1'b0;
    if (z_in > DEG90_Q16) begin
      z_fold = z_in - DEG180_Q16;
      neg_in = 1'b1;
    end else if (z_in < -DEG90_Q16) begin
      z_fold = z_in + DEG180_Q16;
      neg_in = 1'b1;
    end
    gain_prod = 45'(pivot_dist) * 45'(GAIN_Q30);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xs[0]  <= $signed(ROT_W'(gain_prod >> 14));
      ys[0]  <= '0;
      zs[0]  <= z_fold;
      ngs[0] <= neg_in;
      act[0] <= in_action;
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic signed [ROT_W-1:0] x_next;
    logic signed [ROT_W-1:0] y_next;
    logic signed [ANG_W-1:0] z_next;

    always_comb begin
      logic signed [ROT_W-1:0] dx;
      logic signed [ROT_W-1:0] dy;
      dx = ys[i] >>> i;
      dy = xs[i] >>> i;
      if (!zs[i][ANG_W-1]) begin
        x_next = xs[i] - dx;
        y_next = ys[i] + dy;
        z_next = zs[i] - atan_q16(i);
      end else begin
        x_next = xs[i] + dx;
        y_next = ys[i] - dy;
        z_next = zs[i] + atan_q16(i);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        xs[i+1]  <= x_next;
        ys[i+1]  <= y_next;
        zs[i+1]  <= z_next;
        ngs[i+1] <= ngs[i];
        act[i+1] <= act[i];
      end
    end
  end

  logic signed [ROT_W-1:0] x_rnd;
  logic signed [ROT_W-1:0] y_rnd;
  logic signed [PT_W-1:0]  px_next;
  logic signed [PT_W-1:0]  py_next;

  always_comb begin
    x_rnd = (xs[STAGES] + RND16) >>> 16;
    y_rnd = (ys[STAGES] + RND16) >>> 16;
    if (ngs[STAGES]) begin
      py_next = -$signed(x_rnd[PT_W-1:0]);
      px_next = -$signed(y_rnd[PT_W-1:0]);
    end else begin
      py_next = $signed(x_rnd[PT_W-1:0]);
      px_next = $signed(y_rnd[PT_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_px     <= px_next;
      out_py     <= py_next;
      out_action <= act[STAGES];
    end
  end

endmodule

`default_nettype wire

/* rtl/glsa_geo.sv */
// Circle intersection pipeline with a pipelined integer square root.
`default_nettype none

module glsa_geo (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              en,
  input  wire glsa_pkg::cfg_t                    cfg,
  input  wire logic                              in_valid,
  input  wire logic                              in_action,
  input  wire logic signed [glsa_pkg::PT_W-1:0]  in_px,
  input  wire logic signed [glsa_pkg::PT_W-1:0]  in_py,
  output logic                                   out_valid,
  output logic                                   out_bad,
  output logic                                   out_den_zero,
  output logic signed [glsa_pkg::NUM_W-1:0]      out_num,
  output logic signed [glsa_pkg::NUM_W-1:0]      out_den
);
  import glsa_pkg::*;

  localparam int unsigned SQ_STAGES = 32;
  localparam int unsigned K_W = 35;

  // Stage 1: offsets from the selected servo pivot.
  logic                    v1;
  logic signed [OFS_W-1:0] ex1, ey1;
  logic signed [15:0]      cx_sel;

  assign cx_sel = in_action ? cfg.pitch_servo_x : cfg.yaw_servo_x;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ex1 <= OFS_W'(in_px) - OFS_W'(cx_sel);
      ey1 <= OFS_W'(in_py) - OFS_W'(cfg.servo_y);
    end
  end

  // Stage 2: squares.
  logic                    v2;
  logic signed [2*OFS_W-1:0] exx2, eyy2;
  logic [29:0]             r1sq2, r2sq2;
  logic [31:0]             sum2_2;
  logic [30:0]             dif2_2;
  logic signed [OFS_W-1:0] ex2, ey2;
  logic [15:0]             rsum;
  logic signed [15:0]      rdif;
  logic signed [31:0]      rdif_sq;

  always_comb begin
    rsum = 16'(cfg.horn_radius) + 16'(cfg.rod_length);
    rdif = $signed({1'b0, cfg.horn_radius}) - $signed({1'b0, cfg.rod_length});
    rdif_sq = 32'(rdif) * 32'(rdif);
  end

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      exx2   <= (2*OFS_W)'(ex1) * (2*OFS_W)'(ex1);
      eyy2   <= (2*OFS_W)'(ey1) * (2*OFS_W)'(ey1);
      r1sq2  <= 30'(cfg.horn_radius) * 30'(cfg.horn_radius);
      r2sq2  <= 30'(cfg.rod_length) * 30'(cfg.rod_length);
      sum2_2 <= 32'(rsum) * 32'(rsum);
      dif2_2 <= rdif_sq[30:0];
      ex2    <= ex1;
      ey2    <= ey1;
    end
  end

  // Stage 3: squared distance and the radius term.
  logic                    v3;
  logic signed [38:0]      dd3;
  logic signed [30:0]      q3;
  logic [31:0]             sum2_3;
  logic [30:0]             dif2_3;
  logic signed [OFS_W-1:0] ex3, ey3;

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dd3    <= 39'(exx2) + 39'(eyy2);
      q3     <= $signed({1'b0, r1sq2}) - $signed({1'b0, r2sq2});
      sum2_3 <= sum2_2;
      dif2_3 <= dif2_2;
      ex3    <= ex2;
      ey3    <= ey2;
    end
  end

  // Stage 4: reach tests.
  logic                    v4;
  logic                    bad4;
  logic [31:0]             s1_4, s2_4;
  logic signed [K_W-1:0]   k4;
  logic signed [OFS_W-1:0] ex4, ey4;
  logic signed [39:0]      s1_full, s2_full, k_full;

  always_comb begin
    s1_full = $signed({8'b0, sum2_3}) - 40'(dd3);
    s2_full = 40'(dd3) - $signed({9'b0, dif2_3});
    k_full  = 40'(dd3) + 40'(q3);
  end

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (en) v4 <= v3;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bad4 <= (dd3 <= 39'sd0) || s1_full[39] || s2_full[39];
      s1_4 <= s1_full[31:0];
      s2_4 <= s2_full[31:0];
      k4   <= k_full[K_W-1:0];
      ex4  <= ex3;
      ey4  <= ey3;
    end
  end

  // Stage 5 feeds the root: one result bit per stage after it.
  logic                    sv  [SQ_STAGES+1];
  logic                    sb  [SQ_STAGES+1];
  logic [63:0]             rv  [SQ_STAGES+1];
  logic [63:0]             rr  [SQ_STAGES+1];
  logic signed [K_W-1:0]   sk  [SQ_STAGES+1];
  logic signed [OFS_W-1:0] sex [SQ_STAGES+1];
  logic signed [OFS_W-1:0] sey [SQ_STAGES+1];

  always_ff @(posedge clk) begin
    if (rst) sv[0] <= 1'b0;
    else if (en) sv[0] <= v4;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rv[0]  <= 64'(s1_4) * 64'(s2_4);
      rr[0]  <= '0;
      sb[0]  <= bad4;
      sk[0]  <= k4;
      sex[0] <= ex4;
      sey[0] <= ey4;
    end
  end

  for (genvar j = 0; j < SQ_STAGES; j++) begin : g_sqrt
    localparam logic [63:0] BITC = 64'd1 << (62 - 2*j);
    logic [63:0] v_next, r_next, trial;

    always_comb begin
      trial = rr[j] + BITC;
      if (rv[j] >= trial) begin
        v_next = rv[j] - trial;
        r_next = (rr[j] >> 1) + BITC;
      end else begin
        v_next = rv[j];
        r_next = rr[j] >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) sv[j+1] <= 1'b0;
      else if (en) sv[j+1] <= sv[j];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rv[j+1]  <= v_next;
        rr[j+1]  <= r_next;
        sb[j+1]  <= sb[j];
        sk[j+1]  <= sk[j];
        sex[j+1] <= sex[j];
        sey[j+1] <= sey[j];
      end
    end
  end

  // Stage 6: products.
  logic                    v6, bad6;
  logic signed [NUM_W-1:0] m1, m2, m3, m4;
  logic signed [32:0]      root_s;

  assign root_s = $signed({1'b0, rr[SQ_STAGES][31:0]});

  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else if (en) v6 <= sv[SQ_STAGES];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1   <= NUM_W'(sk[SQ_STAGES]) * NUM_W'(sex[SQ_STAGES]);
      m2   <= NUM_W'(root_s) * NUM_W'(sey[SQ_STAGES]);
      m3   <= NUM_W'(sk[SQ_STAGES]) * NUM_W'(sey[SQ_STAGES]);
      m4   <= NUM_W'(root_s) * NUM_W'(sex[SQ_STAGES]);
      bad6 <= sb[SQ_STAGES];
    end
  end

  // Stage 7: numerator and denominator.
  logic                    v7, bad7;
  logic signed [NUM_W-1:0] num7, den7;

  always_ff @(posedge clk) begin
    if (rst) v7 <= 1'b0;
    else if (en) v7 <= v6;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num7 <= m1 - m2;
      den7 <= m3 + m4;
      bad7 <= bad6;
    end
  end

  // Stage 8: make the denominator positive.
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= v7;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_bad      <= bad7;
      out_den_zero <= (den7 == '0);
      if (den7[NUM_W-1]) begin
        out_num <= -num7;
        out_den <= -den7;
      end else begin
        out_num <= num7;
        out_den <= den7;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/glsa_atan.sv */
// Pipelined vectoring CORDIC that turns the horn offset into the servo angle.
`default_nettype none

module glsa_atan #(
  parameter int unsigned STAGES = glsa_pkg::CORDIC_STAGES_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              en,
  input  wire logic                              in_valid,
  input  wire logic                              in_bad,
  input  wire logic                              in_den_zero,
  input  wire logic signed [glsa_pkg::NUM_W-1:0] in_num,
  input  wire logic signed [glsa_pkg::NUM_W-1:0] in_den,
  output logic                                   out_valid,
  output logic signed [15:0]                     servo_angle,
  output logic                                   reachable
);
  import glsa_pkg::*;

  localparam logic signed [ANG_W-1:0] RND8 = 26'sd128;

  logic signed [AT_W-1:0]  xs  [STAGES+1];
  logic signed [AT_W-1:0]  ys  [STAGES+1];
  logic signed [ANG_W-1:0] zs  [STAGES+1];
  logic                    vld [STAGES+1];
  logic                    bd  [STAGES+1];
  logic                    dz  [STAGES+1];
  logic                    npos[STAGES+1];
  logic                    nneg[STAGES+1];

  assign vld[0]  = in_valid;
  assign bd[0]   = in_bad;
  assign dz[0]   = in_den_zero;
  assign npos[0] = !in_num[NUM_W-1] && (in_num != '0);
  assign nneg[0] = in_num[NUM_W-1];
  assign xs[0]   = AT_W'(in_den);
  assign ys[0]   = AT_W'(in_num);
  assign zs[0]   = '0;

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic signed [AT_W-1:0]  x_next;
    logic signed [AT_W-1:0]  y_next;
    logic signed [ANG_W-1:0] z_next;

    always_comb begin
      logic signed [AT_W-1:0] dx;
      logic signed [AT_W-1:0] dy;
      dx = ys[i] >>> i;
      dy = xs[i] >>> i;
      if (!ys[i][AT_W-1] && (ys[i] != '0)) begin
        x_next = xs[i] + dx;
        y_next = ys[i] - dy;
        z_next = zs[i] + atan_q16(i);
      end else begin
        x_next = xs[i] - dx;
        y_next = ys[i] + dy;
        z_next = zs[i] - atan_q16(i);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) vld[i+1] <= 1'b0;
      else if (en) vld[i+1] <= vld[i];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        xs[i+1]   <= x_next;
        ys[i+1]   <= y_next;
        zs[i+1]   <= z_next;
        bd[i+1]   <= bd[i];
        dz[i+1]   <= dz[i];
        npos[i+1] <= npos[i];
        nneg[i+1] <= nneg[i];
      end
    end
  end

  logic signed [ANG_W-1:0] z_rnd;
  logic signed [15:0]      ang_next;

  always_comb begin
    z_rnd = (zs[STAGES] + RND8) >>> 8;
    if (bd[STAGES]) begin
      ang_next = '0;
    end else if (dz[STAGES]) begin
      if (npos[STAGES]) ang_next = OUT_LIMIT;
      else if (nneg[STAGES]) ang_next = -OUT_LIMIT;
      else ang_next = '0;
    end else if (z_rnd > ANG_W'(OUT_LIMIT)) begin
      ang_next = OUT_LIMIT;
    end else if (z_rnd < -ANG_W'(OUT_LIMIT)) begin
      ang_next = -OUT_LIMIT;
    end else begin
      ang_next = z_rnd[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= vld[STAGES];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      servo_angle <= ang_next;
      reachable   <= !bd[STAGES];
    end
  end

endmodule

`default_nettype wire

/* bench/tb.sv */
// Self-checking testbench for the gimbal linkage servo angle core.
`timescale 1ns / 100ps

module tb;
  import glsa_pkg::*;

  localparam int unsigned STAGES = CORDIC_STAGES_DEF;
  localparam int unsigned DRAIN_CYCLES = 2 * STAGES + 50;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic action = 1'b0;
  logic signed [15:0] gimbal_angle = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] servo_angle;
  logic reachable;

  typedef struct {
    logic signed [15:0] angle;
    logic               reach;
  } servo_result_t;

  servo_result_t pending_angles[$];
  cfg_t linkage;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles = 0;
  int errors = 0;
  int requests_sent = 0;
  int results_seen = 0;
  int unreachable_seen = 0;
  longint cycles = 0;
  longint atan_deg_q16[16] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                               29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};

  gimbal_linkage_servo_angle_core dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .action(action),
    .gimbal_angle(gimbal_angle),
    .out_valid(out_valid), .out_ready(out_ready), .servo_angle(servo_angle),
    .reachable(reachable)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results pending", cycles,
               pending_angles.size());
      $display("Verification failed");
      $finish;
    end
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= r + bitv) begin
        v -= r + bitv;
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    return r;
  endfunction

  // Places the linkage hole: sine and cosine of the gimbal angle times the pivot distance.
  function automatic void place_hole(input longint a_q8, input longint pdist,
                                     output longint hx, output longint hy);
    longint z, cx, sy, dx, dy;
    bit flip;
    z = a_q8 * 256;
    flip = 0;
    if (z > 64'sd5898240) begin
      z -= 64'sd11796480;
      flip = 1;
    end else if (z < -64'sd5898240) begin
      z += 64'sd11796480;
      flip = 1;
    end
    cx = (pdist * 64'sd652032875) >>> 14;
    sy = 0;
    for (int i = 0; i < STAGES; i++) begin
      dx = sy >>> i;
      dy = cx >>> i;
      if (z >= 0) begin
        cx -= dx; sy += dy; z -= atan_deg_q16[i];
      end else begin
        cx += dx; sy -= dy; z += atan_deg_q16[i];
      end
    end
    cx = (cx + 32768) >>> 16;
    sy = (sy + 32768) >>> 16;
    if (flip) begin
      cx = -cx;
      sy = -sy;
    end
    hx = sy;
    hy = cx;
  endfunction

  function automatic longint horn_atan(longint num, longint den);
    longint x, y, z, dx, dy;
    x = den;
    y = num;
    z = 0;
    for (int i = 0; i < STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += atan_deg_q16[i];
      end else begin
        x -= dx; y += dy; z -= atan_deg_q16[i];
      end
    end
    z = (z + 128) >>> 8;
    if (z > 23040) z = 23040;
    if (z < -23040) z = -23040;
    return z;
  endfunction

  function automatic servo_result_t servo_for(logic sel, logic signed [15:0] ang);
    servo_result_t res;
    longint px, py, cx, cy, r1, r2, ex, ey, dd, s1, s2, root, k, num, den;
    longint unsigned prod;
    cx = sel ? longint'(linkage.pitch_servo_x) : longint'(linkage.yaw_servo_x);
    cy = longint'(linkage.servo_y);
    r1 = longint'({1'b0, linkage.horn_radius});
    r2 = longint'({1'b0, linkage.rod_length});
    place_hole(longint'(ang), longint'({1'b0, linkage.pivot_distance}), px, py);
    ex = px - cx;
    ey = py - cy;
    dd = ex * ex + ey * ey;
    s1 = (r1 + r2) * (r1 + r2) - dd;
    s2 = dd - (r1 - r2) * (r1 - r2);
    res.angle = '0;
    res.reach = 1'b0;
    if (dd <= 0 || s1 < 0 || s2 < 0) return res;
    prod = longint'(s1) * longint'(s2);  // wraps at 64 bits, as the datapath does
    root = longint'(int_sqrt(prod));
    k = dd + r1 * r1 - r2 * r2;
    num = k * ex - root * ey;
    den = k * ey + root * ex;
    res.reach = 1'b1;
    if (den == 0) begin
      res.angle = num > 0 ? OUT_LIMIT : (num < 0 ? -OUT_LIMIT : 16'sd0);
    end else begin
      if (den < 0) begin
        den = -den;
        num = -num;
      end
      res.angle = 16'(horn_atan(num, den));
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("Mismatch on %s at cycle %0d: got %0d, expected %0d", what, cycles, got, want);
    errors++;
  endtask

  // Result checker.
  always @(posedge clk) begin
    servo_result_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (!reachable) unreachable_seen++;
      if (pending_angles.size() == 0) begin
        report_mismatch("unexpected result", int'(servo_angle), 0);
      end else begin
        want = pending_angles.pop_front();
        if (servo_angle !== want.angle)
          report_mismatch("servo_angle", int'(servo_angle), int'(want.angle));
        if (reachable !== want.reach)
          report_mismatch("reachable", int'(reachable), int'(want.reach));
      end
    end
  end

  // Result receiver, with an optional long hold-off.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_request(logic sel, logic signed [15:0] ang);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    action <= sel;
    gimbal_angle <= ang;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_angles.push_back(servo_for(sel, ang));
    requests_sent++;
  endtask

  task automatic drain;
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_angles.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_PIVOT_DISTANCE: linkage.pivot_distance = value[14:0];
      REG_YAW_SERVO_X:    linkage.yaw_servo_x = value;
      REG_PITCH_SERVO_X:  linkage.pitch_servo_x = value;
      REG_SERVO_Y:        linkage.servo_y = value;
      REG_HORN_RADIUS:    linkage.horn_radius = value[14:0];
      REG_ROD_LENGTH:     linkage.rod_length = value[14:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_linkage(int pd, int yx, int px, int sy, int hr, int rl);
    write_reg(REG_PIVOT_DISTANCE, 16'(pd));
    write_reg(REG_YAW_SERVO_X, 16'(yx));
    write_reg(REG_PITCH_SERVO_X, 16'(px));
    write_reg(REG_SERVO_Y, 16'(sy));
    write_reg(REG_HORN_RADIUS, 16'(hr));
    write_reg(REG_ROD_LENGTH, 16'(rl));
  endtask

  function automatic int jitter(int base, int span, int lo, int hi);
    int v;
    v = base + $urandom_range(2 * span) - span;
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // Mostly a linkage near the nominal one, so that most requests are reachable.
  task automatic random_linkage;
    if ($urandom_range(3) != 0) begin
      write_linkage(jitter(17203, 5000, 0, 32767), jitter(-11469, 4000, -32768, 32767),
                    jitter(-10445, 4000, -32768, 32767), jitter(11878, 4000, -32768, 32767),
                    jitter(4506, 2000, 0, 32767), jitter(11469, 3000, 0, 32767));
    end else begin
      write_linkage($urandom_range(32767), $urandom_range(65535), $urandom_range(65535),
                    $urandom_range(65535), $urandom_range(32767), $urandom_range(32767));
    end
  endtask

  function automatic logic signed [15:0] random_angle;
    case ($urandom_range(3))
      0: return 16'($urandom_range(46080) - 23040);
      1: return 16'($urandom_range(8000) - 4000);
      2: return $urandom_range(1) ? 16'sd23040 - 16'($urandom_range(300))
                                  : -16'sd23040 + 16'($urandom_range(300));
      default: return 16'($urandom_range(1024) - 512);
    endcase
  endfunction

  task automatic test_nominal_extremes;
    logic signed [15:0] angles[8] = '{16'sd0, 16'sd1, -16'sd1, 16'sd23040, -16'sd23040,
                                     16'sd11520, -16'sd11520, 16'sd23039};
    foreach (angles[i]) begin
      send_request(1'b0, angles[i]);
      send_request(1'b1, angles[i]);
    end
    drain();
  endtask

  task automatic test_degenerate_geometry;
    // Rod and horn too short to reach the hole.
    write_linkage(17203, -11469, -10445, 11878, 0, 0);
    send_request(1'b0, 16'sd0);
    send_request(1'b1, 16'sd5000);
    drain();
    // Hole sitting exactly on the servo pivot.
    write_linkage(0, 0, 0, 0, 4506, 11469);
    send_request(1'b0, 16'sd100);
    drain();
    // Circles touching at one point, with no vertical offset left.
    write_linkage(0, -3000, 3000, 0, 1000, 2000);
    send_request(1'b0, 16'sd0);
    send_request(1'b1, -16'sd0);
    drain();
    // Register extremes; indexes past the last register must change nothing.
    write_linkage(32767, -32768, 32767, -32768, 32767, 32767);
    write_reg(3'd6, 16'hFFFF);
    write_reg(3'd7, 16'h1234);
    send_request(1'b0, 16'sd23040);
    send_request(1'b1, -16'sd23040);
    drain();
    write_linkage(0, 32767, -32768, 32767, 0, 32767);
    send_request(1'b0, 16'sd0);
    send_request(1'b1, 16'sd12000);
    drain();
  endtask

  task automatic test_random_traffic(int send_pct, int recv_pct, int per_block);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int b = 0; b < 5; b++) begin
      random_linkage();
      // Some stretches run without any idling at all.
      if (b == 2) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else begin
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
      end
      repeat (per_block) send_request(1'($urandom_range(1)), random_angle());
      drain();
    end
  endtask

  task automatic test_backpressure;
    write_linkage(17203, -11469, -10445, 11878, 4506, 11469);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_cycles = 400;
    repeat (200) send_request(1'($urandom_range(1)), random_angle());
    drain();
  endtask

  initial begin
    linkage = '{pivot_distance: PIVOT_DISTANCE_RST, yaw_servo_x: YAW_SERVO_X_RST,
                pitch_servo_x: PITCH_SERVO_X_RST, servo_y: SERVO_Y_RST,
                horn_radius: HORN_RADIUS_RST, rod_length: ROD_LENGTH_RST};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_nominal_extremes();
    test_degenerate_geometry();
    test_random_traffic(27, 72, 80);
    test_random_traffic(72, 27, 80);
    test_random_traffic(0, 0, 80);
    test_backpressure();
    $display("Sent %0d gimbal requests over nominal, degenerate and random linkages;",
             requests_sent);
    $display("checked %0d servo angles, %0d of them unreachable, %0d mismatches.",
             results_seen, unreachable_seen, errors);
    if (errors == 0 && pending_angles.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
